// ===== sv/cbqr_pkg.sv =====
// ---------------------------------------------------------------------------
// cbqr_pkg
// Shared types, widths and constants of the circle band quadtree refiner.
// ---------------------------------------------------------------------------
package cbqr_pkg;

	// field widths of the ports
	localparam int CODE_W     = 48;
	localparam int LEVEL_W    = 5;
	localparam int CENTER_W   = 25;
	localparam int LEN_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// coordinate width and fraction bits of the diagonal factor
	localparam int COORD_BITS       = 24;
	localparam int EXTENT_FRAC_BITS = 16;

	localparam int CW     = COORD_BITS;
	localparam int SIZE_W = CW + 1;
	// cell centre in 1/256 cells, one carry bit
	localparam int NC_W   = CW + 9;
	localparam int CEN_SH_W = CENTER_W + 8;
	localparam int DIST_W = (NC_W > CEN_SH_W) ? NC_W : CEN_SH_W;

	// sqrt(1/2) rounded to EXTENT_FRAC_BITS fraction bits
	localparam longint unsigned K_FACTOR =
		(64'd70710678 * (64'd1 << EXTENT_FRAC_BITS) + 64'd50000000) / 64'd100000000;
	localparam int K_W     = EXTENT_FRAC_BITS;
	localparam int FRAC_SH = EXTENT_FRAC_BITS - 8;
	localparam int PROD_W  = K_W + CW + 1;
	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'((64'd1 << FRAC_SH) >> 1);
	localparam int HD_W    = PROD_W - FRAC_SH;
	localparam int SLACK_W = ((LEN_W > HD_W) ? LEN_W : HD_W) + 1;
	localparam int UP_W    = ((LEN_W > SLACK_W) ? LEN_W : SLACK_W) + 1;

	// squares are built from three half-width partial products
	localparam int DL = (DIST_W + 1) / 2;
	localparam int DH = DIST_W - DL;
	localparam int UL = (UP_W + 1) / 2;
	localparam int UH = UP_W - UL;
	localparam int LL = (LEN_W + 1) / 2;
	localparam int LH = LEN_W - LL;

	localparam int DSQ_W  = 2 * DIST_W;
	localparam int D2_W   = DSQ_W + 1;
	localparam int UP2_W  = 2 * UP_W;
	localparam int LO2_W  = 2 * LEN_W;
	localparam int CMP_W0 = (D2_W > UP2_W) ? D2_W : UP2_W;
	localparam int CMP_W  = (CMP_W0 > LO2_W) ? CMP_W0 : LO2_W;

	localparam logic [LEVEL_W-1:0] DEPTH_MIN  = LEVEL_W'(1);
	localparam logic [LEVEL_W-1:0] DEPTH_MAX  = LEVEL_W'(COORD_BITS);
	localparam logic [1:0]         LAST_CHILD = 2'd3;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_DEPTH     = 3'd0,
		REG_CENTER_X       = 3'd1,
		REG_CENTER_Y       = 3'd2,
		REG_CIRCLE_RADIUS  = 3'd3,
		REG_BAND_WIDTH     = 3'd4,
		REG_FULL_SPLIT_LVL = 3'd5,
		REG_BAND_SPLIT_LVL = 3'd6
	} cfg_reg_e;

	localparam logic [LEVEL_W-1:0]  RST_GRID_DEPTH     = 5'd20;
	localparam logic [CENTER_W-1:0] RST_CENTER_X       = 25'd524288;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y       = 25'd524288;
	localparam logic [LEN_W-1:0]    RST_CIRCLE_RADIUS  = 32'd67108864;
	localparam logic [LEN_W-1:0]    RST_BAND_WIDTH     = 32'd13421773;
	localparam logic [LEVEL_W-1:0]  RST_FULL_SPLIT_LVL = 5'd4;
	localparam logic [LEVEL_W-1:0]  RST_BAND_SPLIT_LVL = 5'd12;

	typedef struct packed {
		logic [LEVEL_W-1:0]  grid_depth;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [LEN_W-1:0]    circle_radius;
		logic [LEN_W-1:0]    band_width;
		logic [LEVEL_W-1:0]  full_split_lvl;
		logic [LEVEL_W-1:0]  band_split_lvl;
	} cfg_t;

	typedef struct packed {
		logic [CODE_W-1:0]  leaf_code;
		logic [LEVEL_W-1:0] leaf_level;
	} leaf_t;

	typedef struct packed {
		logic [CODE_W-1:0]  child_code;
		logic [LEVEL_W-1:0] child_level;
		logic               was_split;
		logic               last_of_leaf;
	} child_t;

	// leaf data carried down the pipeline
	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [LEVEL_W-1:0] level;
		logic [CW-1:0]      x;
		logic [CW-1:0]      y;
		logic [CW-1:0]      x1;
		logic [CW-1:0]      y1;
		logic               lvl_ok;
		logic               coarse_hit;
		logic               fine_hit;
	} leaf_info_t;

	typedef struct packed {
		logic                valid;
		leaf_info_t          info;
		logic [DIST_W-1:0]   dx;
		logic [DIST_W-1:0]   dy;
		logic [SLACK_W-1:0]  slack;
	} geo_t;

	typedef struct packed {
		logic       valid;
		leaf_info_t info;
		logic       split;
	} dec_t;

endpackage

// ===== sv/cbqr_geom.sv =====
// ---------------------------------------------------------------------------
// cbqr_geom
// Stages 1 and 2: code decode and level checks, then distances from the
// circle centre, band slack and child corner offsets.
// ---------------------------------------------------------------------------
module cbqr_geom import cbqr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  leaf_valid,
	input  leaf_t leaf,
	output logic  leaf_stall,
	input  logic  rdy_dn,
	output geo_t  geo
);

	logic ld_s1, ld_s2;
	logic v_s1, v_s2;

	logic [LEVEL_W-1:0] depth;
	logic [CW-1:0]      x_dec, y_dec;

	logic [CODE_W-1:0]  code_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [CW-1:0]      x_s1, y_s1;
	logic [LEVEL_W-1:0] sh_s1;
	logic               lvl_ok_s1, coarse_s1, fine_s1;

	logic [SIZE_W-1:0]  size_c;
	logic [CW-1:0]      step_c;
	logic [DIST_W-1:0]  ncx_c, ncy_c, cxs_c, cys_c, dx_c, dy_c;
	logic [PROD_W-1:0]  prod_c;
	logic [HD_W-1:0]    hd_c;
	logic [SLACK_W-1:0] slack_c;

	leaf_info_t         info_s2;
	logic [DIST_W-1:0]  dx_s2, dy_s2;
	logic [SLACK_W-1:0] slack_s2;

	assign ld_s2      = !v_s2 || rdy_dn;
	assign ld_s1      = !v_s1 || ld_s2;
	assign leaf_stall = !ld_s1;

	// stage 1: split the code into x and y, clamp depth
	always_comb begin
		x_dec = '0;
		y_dec = '0;
		for (int i = 0; i < CW; i++) begin
			if (2 * i < CODE_W) x_dec[i] = leaf.leaf_code[2 * i];
			if (2 * i + 1 < CODE_W) y_dec[i] = leaf.leaf_code[2 * i + 1];
		end
		if (cfg.grid_depth < DEPTH_MIN) begin
			depth = DEPTH_MIN;
		end else if (cfg.grid_depth > DEPTH_MAX) begin
			depth = DEPTH_MAX;
		end else begin
			depth = cfg.grid_depth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= leaf_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			code_s1   <= leaf.leaf_code;
			level_s1  <= leaf.leaf_level;
			x_s1      <= x_dec;
			y_s1      <= y_dec;
			sh_s1     <= depth - leaf.leaf_level;
			lvl_ok_s1 <= leaf.leaf_level < depth;
			coarse_s1 <= leaf.leaf_level < cfg.full_split_lvl;
			fine_s1   <= leaf.leaf_level < cfg.band_split_lvl;
		end
	end

	// stage 2: centre distance per axis, slack = band + half diagonal
	always_comb begin
		size_c  = SIZE_W'(1) << sh_s1;
		step_c  = CW'(size_c >> 1);
		ncx_c   = DIST_W'({x_s1, 8'b0}) + DIST_W'({size_c, 7'b0});
		ncy_c   = DIST_W'({y_s1, 8'b0}) + DIST_W'({size_c, 7'b0});
		cxs_c   = DIST_W'({cfg.center_x, 8'b0});
		cys_c   = DIST_W'({cfg.center_y, 8'b0});
		dx_c    = (ncx_c >= cxs_c) ? ncx_c - cxs_c : cxs_c - ncx_c;
		dy_c    = (ncy_c >= cys_c) ? ncy_c - cys_c : cys_c - ncy_c;
		// size is a power of two, so size * k is a shift
		prod_c  = PROD_W'(K_FACTOR) << sh_s1;
		hd_c    = HD_W'((prod_c + ROUND_BIAS) >> FRAC_SH);
		slack_c = SLACK_W'(cfg.band_width) + SLACK_W'(hd_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			info_s2.code       <= code_s1;
			info_s2.level      <= level_s1;
			info_s2.x          <= x_s1;
			info_s2.y          <= y_s1;
			info_s2.x1         <= x_s1 + step_c;
			info_s2.y1         <= y_s1 + step_c;
			info_s2.lvl_ok     <= lvl_ok_s1;
			info_s2.coarse_hit <= coarse_s1;
			info_s2.fine_hit   <= fine_s1;
			dx_s2              <= dx_c;
			dy_s2              <= dy_c;
			slack_s2           <= slack_c;
		end
	end

	assign geo = '{valid: v_s2, info: info_s2, dx: dx_s2, dy: dy_s2, slack: slack_s2};

endmodule

// ===== sv/cbqr_band.sv =====
// ---------------------------------------------------------------------------
// cbqr_band
// Stages 3 to 5: band limits, exact squares from partial products and the
// strict band test that sets the split decision.
// ---------------------------------------------------------------------------
module cbqr_band import cbqr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  geo_t geo,
	output logic rdy_up,
	input  logic rdy_dn,
	output dec_t dec
);

	logic ld_s3, ld_s4, ld_s5;
	logic v_s3, v_s4, v_s5;
	leaf_info_t info_s3, info_s4, info_s5;

	logic [UP_W-1:0]     upper_s3;
	logic [LEN_W-1:0]    lower_s3;
	logic [2*DH-1:0]     dx_hh_s3, dy_hh_s3;
	logic [DH+DL-1:0]    dx_hl_s3, dy_hl_s3;
	logic [2*DL-1:0]     dx_ll_s3, dy_ll_s3;

	logic [DSQ_W-1:0]    dx2_s4, dy2_s4;
	logic [2*UH-1:0]     up_hh_s4;
	logic [UH+UL-1:0]    up_hl_s4;
	logic [2*UL-1:0]     up_ll_s4;
	logic [2*LH-1:0]     lo_hh_s4;
	logic [LH+LL-1:0]    lo_hl_s4;
	logic [2*LL-1:0]     lo_ll_s4;

	logic [D2_W-1:0]     d2_s5;
	logic [UP2_W-1:0]    up2_s5;
	logic [LO2_W-1:0]    lo2_s5;

	logic [SLACK_W-1:0]  radius_ext;
	logic                in_band;

	assign ld_s5  = !v_s5 || rdy_dn;
	assign ld_s4  = !v_s4 || ld_s5;
	assign ld_s3  = !v_s3 || ld_s4;
	assign rdy_up = ld_s3;

	assign radius_ext = SLACK_W'(cfg.circle_radius);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld_s3) v_s3 <= geo.valid;
			if (ld_s4) v_s4 <= v_s3;
			if (ld_s5) v_s5 <= v_s4;
		end
	end

	// stage 3: band limits and partial products of the axis distances
	always_ff @(posedge clk) begin
		if (ld_s3) begin
			info_s3  <= geo.info;
			upper_s3 <= UP_W'(cfg.circle_radius) + UP_W'(geo.slack);
			lower_s3 <= (radius_ext > geo.slack) ? LEN_W'(radius_ext - geo.slack) : '0;
			dx_hh_s3 <= (2*DH)'(geo.dx[DIST_W-1:DL]) * (2*DH)'(geo.dx[DIST_W-1:DL]);
			dx_hl_s3 <= (DH+DL)'(geo.dx[DIST_W-1:DL]) * (DH+DL)'(geo.dx[DL-1:0]);
			dx_ll_s3 <= (2*DL)'(geo.dx[DL-1:0]) * (2*DL)'(geo.dx[DL-1:0]);
			dy_hh_s3 <= (2*DH)'(geo.dy[DIST_W-1:DL]) * (2*DH)'(geo.dy[DIST_W-1:DL]);
			dy_hl_s3 <= (DH+DL)'(geo.dy[DIST_W-1:DL]) * (DH+DL)'(geo.dy[DL-1:0]);
			dy_ll_s3 <= (2*DL)'(geo.dy[DL-1:0]) * (2*DL)'(geo.dy[DL-1:0]);
		end
	end

	// stage 4: axis squares, partial products of the limits
	always_ff @(posedge clk) begin
		if (ld_s4) begin
			info_s4  <= info_s3;
			dx2_s4   <= (DSQ_W'(dx_hh_s3) << (2 * DL)) + (DSQ_W'(dx_hl_s3) << (DL + 1))
				+ DSQ_W'(dx_ll_s3);
			dy2_s4   <= (DSQ_W'(dy_hh_s3) << (2 * DL)) + (DSQ_W'(dy_hl_s3) << (DL + 1))
				+ DSQ_W'(dy_ll_s3);
			up_hh_s4 <= (2*UH)'(upper_s3[UP_W-1:UL]) * (2*UH)'(upper_s3[UP_W-1:UL]);
			up_hl_s4 <= (UH+UL)'(upper_s3[UP_W-1:UL]) * (UH+UL)'(upper_s3[UL-1:0]);
			up_ll_s4 <= (2*UL)'(upper_s3[UL-1:0]) * (2*UL)'(upper_s3[UL-1:0]);
			lo_hh_s4 <= (2*LH)'(lower_s3[LEN_W-1:LL]) * (2*LH)'(lower_s3[LEN_W-1:LL]);
			lo_hl_s4 <= (LH+LL)'(lower_s3[LEN_W-1:LL]) * (LH+LL)'(lower_s3[LL-1:0]);
			lo_ll_s4 <= (2*LL)'(lower_s3[LL-1:0]) * (2*LL)'(lower_s3[LL-1:0]);
		end
	end

	// stage 5: squared distance and squared limits
	always_ff @(posedge clk) begin
		if (ld_s5) begin
			info_s5 <= info_s4;
			d2_s5   <= D2_W'(dx2_s4) + D2_W'(dy2_s4);
			up2_s5  <= (UP2_W'(up_hh_s4) << (2 * UL)) + (UP2_W'(up_hl_s4) << (UL + 1))
				+ UP2_W'(up_ll_s4);
			lo2_s5  <= (LO2_W'(lo_hh_s4) << (2 * LL)) + (LO2_W'(lo_hl_s4) << (LL + 1))
				+ LO2_W'(lo_ll_s4);
		end
	end

	// strict on both sides, so a centre hit is never in the band
	assign in_band = (CMP_W'(d2_s5) < CMP_W'(up2_s5)) && (CMP_W'(lo2_s5) < CMP_W'(d2_s5));

	assign dec.valid = v_s5;
	assign dec.info  = info_s5;
	assign dec.split = info_s5.lvl_ok &&
		(info_s5.coarse_hit || (info_s5.fine_hit && in_band));

endmodule

// ===== sv/cbqr_emit.sv =====
// ---------------------------------------------------------------------------
// cbqr_emit
// Output register: passes an unsplit leaf as one word, or steps through the
// four children of a split leaf in Morton order.
// ---------------------------------------------------------------------------
module cbqr_emit import cbqr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  dec_t   dec,
	output logic   rdy_up,
	output logic   child_valid,
	input  logic   child_stall,
	output child_t child
);

	logic               valid_q;
	logic [1:0]         cnt_q;
	logic               split_q;
	logic [CODE_W-1:0]  code_q;
	logic [LEVEL_W-1:0] level_q;
	logic [CW-1:0]      x_q, y_q, x1_q, y1_q;

	logic               fire, last;
	logic [CW-1:0]      cx, cy;
	logic [CODE_W-1:0]  morton;

	assign last   = !split_q || (cnt_q == LAST_CHILD);
	assign fire   = valid_q && !child_stall;
	assign rdy_up = !valid_q || (fire && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (rdy_up) begin
			valid_q <= dec.valid;
			cnt_q   <= '0;
		end else if (fire) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_up) begin
			split_q <= dec.split;
			code_q  <= dec.info.code;
			level_q <= dec.info.level;
			x_q     <= dec.info.x;
			y_q     <= dec.info.y;
			x1_q    <= dec.info.x1;
			y1_q    <= dec.info.y1;
		end
	end

	// child (dx,dy) order: (0,0) (1,0) (0,1) (1,1)
	assign cx = cnt_q[0] ? x1_q : x_q;
	assign cy = cnt_q[1] ? y1_q : y_q;

	always_comb begin
		morton = '0;
		for (int i = 0; i < CW; i++) begin
			if (2 * i < CODE_W) morton[2 * i] = cx[i];
			if (2 * i + 1 < CODE_W) morton[2 * i + 1] = cy[i];
		end
	end

	assign child_valid        = valid_q;
	assign child.child_code   = split_q ? morton : code_q;
	assign child.child_level  = split_q ? level_q + LEVEL_W'(1) : level_q;
	assign child.was_split    = split_q;
	assign child.last_of_leaf = last;

endmodule

// ===== sv/circle_band_quadtree_refiner.sv =====
// ---------------------------------------------------------------------------
// circle_band_quadtree_refiner
// Refines quadtree leaves around a circle band and emits leaves or children.
// ---------------------------------------------------------------------------
// Leaves enter at one per cycle while leaf_stall is low and flow through five
// pipeline stages (decode, axis distances and slack, limits and partial
// products, squares, squared sums) into an output register. An unsplit leaf
// leaves as one word; a split leaf holds the output register for its four
// children, one child per word, and the output register takes the next leaf
// as the last word of the previous one leaves, so the single result port
// sets the pace. Stalls ripple back stage by stage and empty stages keep
// filling, so input is taken while a result waits. Write configuration only
// while no leaf is in flight.
module circle_band_quadtree_refiner import cbqr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  leaf_valid,
	output logic                  leaf_stall,
	input  leaf_t                 leaf,
	output logic                  child_valid,
	input  logic                  child_stall,
	output child_t                child,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	geo_t geo;
	dec_t dec;
	logic band_rdy, emit_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_depth     <= RST_GRID_DEPTH;
			cfg_q.center_x       <= RST_CENTER_X;
			cfg_q.center_y       <= RST_CENTER_Y;
			cfg_q.circle_radius  <= RST_CIRCLE_RADIUS;
			cfg_q.band_width     <= RST_BAND_WIDTH;
			cfg_q.full_split_lvl <= RST_FULL_SPLIT_LVL;
			cfg_q.band_split_lvl <= RST_BAND_SPLIT_LVL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_DEPTH:     cfg_q.grid_depth     <= cfg_data[LEVEL_W-1:0];
				REG_CENTER_X:       cfg_q.center_x       <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:       cfg_q.center_y       <= cfg_data[CENTER_W-1:0];
				REG_CIRCLE_RADIUS:  cfg_q.circle_radius  <= cfg_data[LEN_W-1:0];
				REG_BAND_WIDTH:     cfg_q.band_width     <= cfg_data[LEN_W-1:0];
				REG_FULL_SPLIT_LVL: cfg_q.full_split_lvl <= cfg_data[LEVEL_W-1:0];
				REG_BAND_SPLIT_LVL: cfg_q.band_split_lvl <= cfg_data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	cbqr_geom u_geom (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.leaf_valid (leaf_valid),
		.leaf       (leaf),
		.leaf_stall (leaf_stall),
		.rdy_dn     (band_rdy),
		.geo        (geo)
	);

	cbqr_band u_band (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.geo    (geo),
		.rdy_up (band_rdy),
		.rdy_dn (emit_rdy),
		.dec    (dec)
	);

	cbqr_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.dec         (dec),
		.rdy_up      (emit_rdy),
		.child_valid (child_valid),
		.child_stall (child_stall),
		.child       (child)
	);

endmodule

// ===== tb/sv/tb_circle_band_quadtree_refiner.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_circle_band_quadtree_refiner
// Self-checking bench: every accepted leaf is turned into its expected
// children (or the leaf itself) by a bit-exact model of the band test. Each
// delivered word is compared in order. Directed corner cases come first,
// then the reset config and random configs, leaves mostly near the circle
// band, under random input bursts, output stalls and one long output hold-off.
// ---------------------------------------------------------------------------
module tb_circle_band_quadtree_refiner;
	import cbqr_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 5;
	localparam int LATENCY        = 12;
	localparam int HOLD_CYCLES    = 80;
	localparam int RANDOM_PHASES  = 6;
	localparam int LEAVES_PER_SET = 34;
	localparam int PRESSURE_PHASE = 1;
	localparam int DRAIN_PHASE    = 3;
	localparam int MAX_PRINTED    = 60;
	localparam longint unsigned DIAG_K =
		(64'd70710678 * (64'd1 << EXTENT_FRAC_BITS) + 64'd50000000) / 64'd100000000;
	localparam int DIAG_SH = EXTENT_FRAC_BITS - 8;

	class child_ledger;
		cfg_t   regs;
		child_t expected_children[$];
		int     errors;

		function new();
			regs.grid_depth     = RST_GRID_DEPTH;
			regs.center_x       = RST_CENTER_X;
			regs.center_y       = RST_CENTER_Y;
			regs.circle_radius  = RST_CIRCLE_RADIUS;
			regs.band_width     = RST_BAND_WIDTH;
			regs.full_split_lvl = RST_FULL_SPLIT_LVL;
			regs.band_split_lvl = RST_BAND_SPLIT_LVL;
			errors = 0;
		endfunction

		task report(string what);
			if (errors < MAX_PRINTED) begin
				$display("ERROR at %0t: %s", $realtime, what);
			end
			errors++;
		endtask

		function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_GRID_DEPTH:     regs.grid_depth     = v[LEVEL_W-1:0];
				REG_CENTER_X:       regs.center_x       = v[CENTER_W-1:0];
				REG_CENTER_Y:       regs.center_y       = v[CENTER_W-1:0];
				REG_CIRCLE_RADIUS:  regs.circle_radius  = v[LEN_W-1:0];
				REG_BAND_WIDTH:     regs.band_width     = v[LEN_W-1:0];
				REG_FULL_SPLIT_LVL: regs.full_split_lvl = v[LEVEL_W-1:0];
				REG_BAND_SPLIT_LVL: regs.band_split_lvl = v[LEVEL_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [LEVEL_W-1:0] depth_used();
			if (regs.grid_depth < DEPTH_MIN) return DEPTH_MIN;
			if (regs.grid_depth > DEPTH_MAX) return DEPTH_MAX;
			return regs.grid_depth;
		endfunction

		function logic [CODE_W-1:0] morton_code(logic [CW-1:0] x, logic [CW-1:0] y);
			logic [CODE_W-1:0] c;
			int i;
			c = '0;
			for (i = 0; i < CW; i++) begin
				c[2*i]   = x[i];
				c[2*i+1] = y[i];
			end
			return c;
		endfunction

		// exact squared test in 1/256 cell units
		function bit cell_in_band(logic [CW-1:0] x, logic [CW-1:0] y, logic [63:0] sz);
			logic [63:0]  ncx, ncy, cxs, cys, dxv, dyv, prod, hd, slack, upper, lower;
			logic [127:0] d2;
			ncx = (64'(x) << 8) + (sz << 7);
			ncy = (64'(y) << 8) + (sz << 7);
			cxs = 64'(regs.center_x) << 8;
			cys = 64'(regs.center_y) << 8;
			dxv = (ncx >= cxs) ? ncx - cxs : cxs - ncx;
			dyv = (ncy >= cys) ? ncy - cys : cys - ncy;
			d2 = 128'(dxv) * 128'(dxv) + 128'(dyv) * 128'(dyv);
			prod = sz * DIAG_K;
			hd = (DIAG_SH > 0) ? (prod + ((64'd1 << DIAG_SH) >> 1)) >> DIAG_SH : prod;
			slack = 64'(regs.band_width) + hd;
			upper = 64'(regs.circle_radius) + slack;
			lower = (64'(regs.circle_radius) > slack) ? 64'(regs.circle_radius) - slack : 64'd0;
			return (d2 < 128'(upper) * 128'(upper)) && (128'(lower) * 128'(lower) < d2);
		endfunction

		function void predict_children(leaf_t l);
			logic [CW-1:0]      x, y, step;
			logic [LEVEL_W-1:0] depth;
			logic [63:0]        sz;
			bit                 split;
			child_t             c;
			int                 i;
			for (i = 0; i < CW; i++) begin
				x[i] = l.leaf_code[2*i];
				y[i] = l.leaf_code[2*i+1];
			end
			depth = depth_used();
			split = 1'b0;
			sz = '0;
			if (l.leaf_level < depth) begin
				sz = 64'd1 << (depth - l.leaf_level);
				split = (l.leaf_level < regs.full_split_lvl) ||
					(l.leaf_level < regs.band_split_lvl && cell_in_band(x, y, sz));
			end
			if (!split) begin
				c.child_code   = l.leaf_code;
				c.child_level  = l.leaf_level;
				c.was_split    = 1'b0;
				c.last_of_leaf = 1'b1;
				expected_children = {expected_children, c};
			end else begin
				step = CW'(sz >> 1);
				for (i = 0; i < 4; i++) begin
					// children in morton order, corners wrap at the coordinate width
					c.child_code   = morton_code(CW'(x + (i[0] ? step : '0)),
						CW'(y + (i[1] ? step : '0)));
					c.child_level  = l.leaf_level + LEVEL_W'(1);
					c.was_split    = 1'b1;
					c.last_of_leaf = (i[1:0] == LAST_CHILD);
					expected_children = {expected_children, c};
				end
			end
		endfunction

		task check_child(child_t got);
			child_t want;
			if (expected_children.size() == 0) begin
				report($sformatf("unexpected word code=%h level=%0d", got.child_code,
					got.child_level));
				return;
			end
			want = expected_children.pop_front();
			if (got.child_code !== want.child_code)
				report($sformatf("child_code %h, want %h", got.child_code, want.child_code));
			if (got.child_level !== want.child_level)
				report($sformatf("child_level %0d, want %0d (code %h)", got.child_level,
					want.child_level, want.child_code));
			if (got.was_split !== want.was_split)
				report($sformatf("was_split %b, want %b (code %h)", got.was_split,
					want.was_split, want.child_code));
			if (got.last_of_leaf !== want.last_of_leaf)
				report($sformatf("last_of_leaf %b, want %b (code %h)", got.last_of_leaf,
					want.last_of_leaf, want.child_code));
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  leaf_valid = 1'b0;
	logic                  leaf_stall;
	leaf_t                 leaf = '0;
	logic                  child_valid;
	logic                  child_stall = 1'b0;
	child_t                child;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	child_ledger ledger = new();
	int          stall_mode = 0;
	int          stall_tick = 0;
	int          hold_left = 0;
	bit          hold_req = 1'b0;

	circle_band_quadtree_refiner uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.leaf_valid  (leaf_valid),
		.leaf_stall  (leaf_stall),
		.leaf        (leaf),
		.child_valid (child_valid),
		.child_stall (child_stall),
		.child       (child),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// receiver: random stall pattern from four modes, long hold on request
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 64 == 0) begin
			stall_mode = $urandom_range(0, 3);
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			child_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: child_stall <= 1'b0;
				1: child_stall <= ($urandom_range(0, 3) == 0);
				2: child_stall <= ($urandom_range(0, 9) < 6);
				default: child_stall <= (stall_tick % 3 == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && child_valid && !child_stall) begin
			ledger.check_child(child);
		end
	end

	task automatic send_leaf(leaf_t l);
		@(negedge clk);
		leaf_valid <= 1'b1;
		leaf <= l;
		do @(posedge clk); while (leaf_stall);
		ledger.predict_children(l);
	endtask

	task automatic idle_sender(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			leaf_valid <= 1'b0;
		end
	endtask

	task automatic wait_all_children();
		while (ledger.expected_children.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		ledger.write_reg(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_config(logic [31:0] depth, logic [31:0] cx, logic [31:0] cy,
			logic [31:0] radius, logic [31:0] band, logic [31:0] coarse,
			logic [31:0] fine);
		idle_sender(1);
		wait_all_children();
		repeat (LATENCY) @(posedge clk);
		write_reg(REG_GRID_DEPTH, depth);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CIRCLE_RADIUS, radius);
		write_reg(REG_BAND_WIDTH, band);
		write_reg(REG_FULL_SPLIT_LVL, coarse);
		write_reg(REG_BAND_SPLIT_LVL, fine);
	endtask

	task automatic random_config();
		logic [31:0] depth, span, coarse;
		depth = $urandom_range(2, 24);
		span = 32'd1 << depth;
		coarse = $urandom_range(0, depth / 3);
		apply_config(depth, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
			($urandom_range(0, span / 2) << 8) | $urandom_range(0, 255),
			$urandom_range(0, 3 * 256), coarse, $urandom_range(coarse, depth));
	endtask

	// mostly cells near the circle, some anywhere in the domain, some raw noise
	function automatic leaf_t random_leaf();
		logic [LEVEL_W-1:0] depth, level;
		logic [63:0]        sz;
		logic [CW-1:0]      x, y;
		longint             px, py, rc, diag, jit;
		int                 pick;
		leaf_t              l;
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			l.leaf_code = CODE_W'({$urandom, $urandom});
			l.leaf_level = LEVEL_W'($urandom_range(0, 31));
			return l;
		end
		depth = ledger.depth_used();
		level = LEVEL_W'($urandom_range(0, depth));
		sz = 64'd1 << (depth - level);
		if (pick < 40) begin
			x = CW'($urandom) & CW'((64'd1 << depth) - 1);
			y = CW'($urandom) & CW'((64'd1 << depth) - 1);
		end else begin
			rc = longint'(ledger.regs.circle_radius >> 8);
			diag = rc * 181 / 256;
			px = longint'(ledger.regs.center_x);
			py = longint'(ledger.regs.center_y);
			case ($urandom_range(0, 5))
				0: px = px + rc;
				1: px = px - rc;
				2: py = py + rc;
				3: py = py - rc;
				4: begin px = px + diag; py = py - diag; end
				default: begin px = px - diag; py = py + diag; end
			endcase
			jit = longint'(sz);
			px = px + longint'($urandom_range(0, 32'(2 * jit))) - jit;
			py = py + longint'($urandom_range(0, 32'(2 * jit))) - jit;
			x = CW'(px);
			y = CW'(py);
		end
		// a few corners stay unaligned
		if ($urandom_range(0, 9) != 0) begin
			x = x & ~CW'(sz - 1);
			y = y & ~CW'(sz - 1);
		end
		l.leaf_code = ledger.morton_code(x, y);
		l.leaf_level = level;
		return l;
	endfunction

	initial begin
		int phase, sent, burst, b;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: root, out of range levels, coordinate wrap, band edges
		send_leaf(leaf_t'{48'h0, 5'd0});
		send_leaf(leaf_t'{48'hFFFF_FFFF_FFFF, 5'd31});
		send_leaf(leaf_t'{48'h0, 5'd20});
		send_leaf(leaf_t'{ledger.morton_code(24'hFFFFFF, 24'hFFFFFF), 5'd2});
		send_leaf(leaf_t'{ledger.morton_code(24'd786432, 24'd524288), 5'd11});
		send_leaf(leaf_t'{ledger.morton_code(24'd786432, 24'd524288), 5'd12});
		send_leaf(leaf_t'{ledger.morton_code(24'd524288, 24'd524288), 5'd4});
		send_leaf(leaf_t'{ledger.morton_code(24'd0, 24'd0), 5'd8});
		send_leaf(leaf_t'{ledger.morton_code(24'd12345, 24'd67891), 5'd10});
		send_leaf(leaf_t'{48'h5555_5555_5555, 5'd6});
		send_leaf(leaf_t'{48'hAAAA_AAAA_AAAA, 5'd6});

		// zero radius and band, centre on the domain edge: strict test at d2 = 0
		apply_config(24, 32'd16777216, 32'd16777216, 0, 0, 0, 24);
		send_leaf(leaf_t'{ledger.morton_code(24'hFFFFFF, 24'hFFFFFF), 5'd23});
		send_leaf(leaf_t'{ledger.morton_code(24'hFFFFFE, 24'hFFFFFF), 5'd23});
		send_leaf(leaf_t'{ledger.morton_code(24'hFFFFFE, 24'hFFFFFE), 5'd23});
		send_leaf(leaf_t'{ledger.morton_code(24'hFFFFFF, 24'hFFFFFF), 5'd24});
		send_leaf(leaf_t'{48'h0, 5'd0});

		// depth below range, everything saturated
		apply_config(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31, 31);
		send_leaf(leaf_t'{48'h1234_5678_9ABC, 5'd0});
		send_leaf(leaf_t'{48'hFFFF_FFFF_FFFF, 5'd1});
		send_leaf(leaf_t'{48'hFFFF_FFFF_FFFF, 5'd31});

		// depth above range, centre beyond the grid
		apply_config(31, 32'h1FF_FFFF, 32'h1FF_FFFF, 32'hFFFF_FFFF, 0, 1, 31);
		send_leaf(leaf_t'{48'h0, 5'd0});
		send_leaf(leaf_t'{ledger.morton_code(24'd0, 24'd0), 5'd3});
		send_leaf(leaf_t'{ledger.morton_code(24'hFFFFFF, 24'd0), 5'd1});
		send_leaf(leaf_t'{48'hFFFF_FFFF_FFFF, 5'd5});

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				apply_config(RST_GRID_DEPTH, RST_CENTER_X, RST_CENTER_Y, RST_CIRCLE_RADIUS,
					RST_BAND_WIDTH, RST_FULL_SPLIT_LVL, RST_BAND_SPLIT_LVL);
			end else begin
				random_config();
			end
			sent = 0;
			while (sent < LEAVES_PER_SET) begin
				burst = $urandom_range(1, 12);
				for (b = 0; b < burst && sent < LEAVES_PER_SET; b++) begin
					send_leaf(random_leaf());
					sent++;
					// output held off while input keeps coming, pipe must back up
					if (phase == PRESSURE_PHASE && sent == 8) hold_req = 1'b1;
					if (phase == DRAIN_PHASE && sent == LEAVES_PER_SET / 2) begin
						idle_sender(1);
						wait_all_children();
					end
				end
				if (phase != PRESSURE_PHASE && $urandom_range(0, 2) != 0) begin
					idle_sender($urandom_range(1, 8));
				end
			end
		end

		idle_sender(1);
		wait_all_children();
		repeat (LATENCY) @(posedge clk);
		if (ledger.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
